>>> hw/rtl/cvs_pkg.sv
// Shared constants and types for the cell voltage sorter.
// Used by cvs_cell and cell_voltage_sort_with_index; no dependencies.
`default_nettype none
package cvs_pkg;

  localparam int MAX_CELLS  = 16;
  localparam int VOLT_W     = 16;
  localparam int CELL_NUM_W = 4;
  localparam int CFG_W      = 5;
  localparam int CNT_W      = $clog2(MAX_CELLS + 1);
  localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CELL_COUNT_RESET = CFG_W'(16);

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } cvs_state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic occ;      // cell holds an entry of this batch
    logic at_fill;  // cell is the first free slot
    logic insert;   // insert beat this cycle
    logic shift;    // drain beat taken: move toward cell 0
  } cvs_cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/cvs_cell.sv
// One slot of the insertion chain: holds a voltage and its cell number.
// Depends on cvs_pkg.
`default_nettype none
module cvs_cell
  import cvs_pkg::*;
(
  input  wire logic                  clk,
  input  wire cvs_cell_ctl_t         ctl,
  input  wire logic [VOLT_W-1:0]     new_v,
  input  wire logic [CELL_NUM_W-1:0] new_n,
  input  wire logic [VOLT_W-1:0]     left_v,
  input  wire logic [CELL_NUM_W-1:0] left_n,
  input  wire logic                  left_gt,
  input  wire logic [VOLT_W-1:0]     right_v,
  input  wire logic [CELL_NUM_W-1:0] right_n,
  output logic [VOLT_W-1:0]          v,
  output logic [CELL_NUM_W-1:0]      n,
  output logic                       gt
);

  logic take;

  // strictly greater keeps equal voltages in arrival order
  assign gt   = ctl.occ && (v > new_v);
  assign take = gt || ctl.at_fill;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      v <= right_v;
      n <= right_n;
    end else if (ctl.insert && take) begin
      if (left_gt) begin
        v <= left_v;
        n <= left_n;
      end else begin
        v <= new_v;
        n <= new_n;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cell_voltage_sort_with_index.sv
// Stable sorter of cell voltages, keeping each cell's arrival number.
// Top level; instantiates cvs_cell, depends on cvs_pkg.
//
// Input channel (in_valid / in_stall / voltage_mv): one voltage per beat,
// in cell order. While filling, a beat is taken every cycle and placed at
// once into a sorted chain of MAX_CELLS cells (one compare per cell).
// When cell_count voltages are held (0 counts as 1, values above
// MAX_CELLS saturate), the chain drains through the output channel
// (out_valid / out_stall / sorted_voltage_mv, cell_number, last_of_run),
// lowest voltage first, one beat per cycle from cell 0 unless stalled;
// last_of_run marks the final beat. in_stall is high during the drain.
// The first result is shown the cycle after the completing input beat.
// A stalled output holds cell 0 and the chain still. cell_count is written
// by cell_count_we / cell_count_data; the user must do so only while idle,
// which the block does not enforce. Synchronous reset empties the chain and
// sets cell_count to 16; no clearing pass is needed.
`default_nettype none
module cell_voltage_sort_with_index
  import cvs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cell_count_we,
  input  wire logic [CFG_W-1:0]      cell_count_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VOLT_W-1:0]     voltage_mv,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VOLT_W-1:0]          sorted_voltage_mv,
  output logic [CELL_NUM_W-1:0]      cell_number,
  output logic                       last_of_run
);

  cvs_state_t          state, state_next;
  logic [CFG_W-1:0]    cell_count;
  logic [CNT_W-1:0]    fill, fill_next;
  logic [CNT_W-1:0]    remain, remain_next;
  logic [LIM_W-1:0]    limit;
  logic [LIM_W-1:0]    held;
  logic                in_beat, out_beat;
  logic [CELL_NUM_W-1:0] new_n;

  logic [VOLT_W-1:0]     cv [MAX_CELLS];
  logic [CELL_NUM_W-1:0] cn [MAX_CELLS];
  logic                  cgt [MAX_CELLS];
  cvs_cell_ctl_t         ctl [MAX_CELLS];

  assign in_stall  = (state == ST_DRAIN);
  assign out_valid = (state == ST_DRAIN);
  assign in_beat   = in_valid && !in_stall;
  assign out_beat  = out_valid && !out_stall;
  assign new_n     = CELL_NUM_W'(fill);

  assign sorted_voltage_mv = cv[0];
  assign cell_number       = cn[0];
  assign last_of_run       = (remain == CNT_W'(1));

  always_comb begin
    if (cell_count == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(cell_count) > LIM_W'(MAX_CELLS)) begin
      limit = LIM_W'(MAX_CELLS);
    end else begin
      limit = LIM_W'(cell_count);
    end
  end

  assign held = LIM_W'(fill) + LIM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= CELL_COUNT_RESET;
    end else if (cell_count_we) begin
      cell_count <= cell_count_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_FILL;
      fill   <= '0;
      remain <= '0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      remain <= remain_next;
    end
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    remain_next = remain;
    case (state)
      ST_FILL: begin
        if (in_beat) begin
          if (held >= limit) begin
            state_next  = ST_DRAIN;
            fill_next   = '0;
            remain_next = CNT_W'(held);
          end else begin
            fill_next = CNT_W'(held);
          end
        end
      end
      ST_DRAIN: begin
        if (out_beat) begin
          remain_next = remain - CNT_W'(1);
          if (remain == CNT_W'(1)) begin
            state_next = ST_FILL;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
    logic [VOLT_W-1:0]     lv, rv;
    logic [CELL_NUM_W-1:0] ln, rn;
    logic                  lgt;

    assign ctl[i].occ     = (CNT_W'(i) < fill);
    assign ctl[i].at_fill = (CNT_W'(i) == fill);
    assign ctl[i].insert  = in_beat;
    assign ctl[i].shift   = out_beat;

    if (i == 0) begin : g_first
      assign lv  = '0;
      assign ln  = '0;
      assign lgt = 1'b0;
    end else begin : g_mid
      assign lv  = cv[i-1];
      assign ln  = cn[i-1];
      assign lgt = cgt[i-1];
    end

    if (i == MAX_CELLS - 1) begin : g_last
      assign rv = '0;
      assign rn = '0;
    end else begin : g_inner
      assign rv = cv[i+1];
      assign rn = cn[i+1];
    end

    cvs_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[i]),
      .new_v   (voltage_mv),
      .new_n   (new_n),
      .left_v  (lv),
      .left_n  (ln),
      .left_gt (lgt),
      .right_v (rv),
      .right_n (rn),
      .v       (cv[i]),
      .n       (cn[i]),
      .gt      (cgt[i])
    );
  end

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Testbench for cell_voltage_sort_with_index: directed and random batches of
// cell voltages, checked beat by beat against a built-in stable-sort predictor.
// Depends on cvs_pkg and the cell_voltage_sort_with_index RTL only.
`timescale 1ns / 100ps
module testbench;
  import cvs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [VOLT_W-1:0]     volt;
    logic [CELL_NUM_W-1:0] num;
    logic                  last;
  } ranked_cell_t;

  logic clk;
  logic rst;
  logic cell_count_we;
  logic [CFG_W-1:0] cell_count_data;
  logic in_valid;
  logic in_stall;
  logic [VOLT_W-1:0] voltage_mv;
  logic out_valid;
  logic out_stall;
  logic [VOLT_W-1:0] sorted_voltage_mv;
  logic [CELL_NUM_W-1:0] cell_number;
  logic last_of_run;

  // predictor state
  logic [VOLT_W-1:0]     shadow_volt [MAX_CELLS];
  logic [CELL_NUM_W-1:0] shadow_num [MAX_CELLS];
  int                    shadow_fill = 0;
  logic [CFG_W-1:0]      shadow_count = CELL_COUNT_RESET;
  ranked_cell_t          pending_ranks[$];

  int mismatch_count = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  cell_voltage_sort_with_index dut (
    .clk(clk),
    .rst(rst),
    .cell_count_we(cell_count_we),
    .cell_count_data(cell_count_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .voltage_mv(voltage_mv),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sorted_voltage_mv(sorted_voltage_mv),
    .cell_number(cell_number),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int batch_size(input logic [CFG_W-1:0] c);
    int n;
    n = c;
    if (n == 0) n = 1;
    if (n > MAX_CELLS) n = MAX_CELLS;
    return n;
  endfunction

  // insert one voltage into the shadow list; a full batch queues its ranks
  task automatic rank_cell(input logic [VOLT_W-1:0] v);
    int pos;
    int held;
    ranked_cell_t r;
    if (shadow_fill >= MAX_CELLS) shadow_fill = 0;
    pos = shadow_fill;
    while (pos > 0 && shadow_volt[pos-1] > v) begin
      shadow_volt[pos] = shadow_volt[pos-1];
      shadow_num[pos] = shadow_num[pos-1];
      pos--;
    end
    shadow_volt[pos] = v;
    shadow_num[pos] = CELL_NUM_W'(shadow_fill);
    held = shadow_fill + 1;
    if (held < batch_size(shadow_count)) begin
      shadow_fill = held;
    end else begin
      for (int k = 0; k < held; k++) begin
        r.volt = shadow_volt[k];
        r.num = shadow_num[k];
        r.last = (k + 1 == held);
        pending_ranks.push_back(r);
      end
      shadow_fill = 0;
    end
  endtask

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    mismatch_count++;
  endtask

  // check result beats, then track config writes and accepted input beats
  always @(posedge clk) begin
    ranked_cell_t r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_ranks.size() == 0) begin
          note_mismatch("unexpected result beat, voltage", sorted_voltage_mv, -1);
        end else begin
          r = pending_ranks.pop_front();
          if (sorted_voltage_mv !== r.volt)
            note_mismatch("sorted_voltage_mv", sorted_voltage_mv, r.volt);
          if (cell_number !== r.num)
            note_mismatch("cell_number", cell_number, r.num);
          if (last_of_run !== r.last)
            note_mismatch("last_of_run", last_of_run, r.last);
        end
      end
      if (cell_count_we) shadow_count = cell_count_data;
      if (in_valid && !in_stall) rank_cell(voltage_mv);
    end
  end

  // receiver: random stall, or a long hold-off while hold_left runs down
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [VOLT_W-1:0] pick_voltage();
    case ($urandom_range(0, 3))
      0: return VOLT_W'($urandom_range(0, 65535));
      1: return VOLT_W'($urandom_range(3000, 3006));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return VOLT_W'($urandom_range(2500, 4200));
    endcase
  endfunction

  task automatic send_cell(input logic [VOLT_W-1:0] v);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    voltage_mv <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    voltage_mv <= pick_voltage();
  endtask

  // one edge first so the monitor has ranked the last accepted beat
  task automatic wait_idle();
    @(posedge clk);
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cell_count(input logic [CFG_W-1:0] c);
    cell_count_we <= 1'b1;
    cell_count_data <= c;
    @(posedge clk);
    cell_count_we <= 1'b0;
  endtask

  task automatic send_list(input logic [VOLT_W-1:0] vs[$]);
    foreach (vs[i]) send_cell(vs[i]);
    end_burst();
    wait_idle();
  endtask

  // reset count of 16: extremes, ties and reversed order in one batch
  task automatic test_default_batch();
    send_list('{16'hFFFF, 16'h0000, 3300, 3300, 4200, 16'h0000, 16'hFFFF, 2800,
                3300, 1, 16'hFFFE, 3700, 3699, 2, 3300, 4000});
  endtask

  // count 0 acts as 1; count 2 with equal voltages keeps arrival order
  task automatic test_small_counts();
    write_cell_count(CFG_W'(0));
    send_list('{16'h1234});
    write_cell_count(CFG_W'(1));
    send_list('{16'h8001});
    write_cell_count(CFG_W'(2));
    send_list('{3000, 3000});
  endtask

  // count lowered below the held number: next beat flushes all held cells
  task automatic test_lowered_mid_batch();
    write_cell_count(CFG_W'(5));
    send_list('{4100, 3900, 4000});
    write_cell_count(CFG_W'(2));
    send_list('{3800});
  endtask

  // receiver holds off long enough for the sender to back up
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    stall_pct = 0;
    write_cell_count(CFG_W'(16));
    hold_left = 300;
    repeat (48) send_cell(pick_voltage());
    end_burst();
    wait_idle();
  endtask

  task automatic test_random_batches(input int idle_pct, input int busy_pct,
                                     input int first_count, input int n_items);
    int sent;
    int n;
    int cfg;
    send_idle_pct = idle_pct;
    stall_pct = busy_pct;
    sent = 0;
    cfg = first_count;
    while (sent < n_items) begin
      wait_idle();
      write_cell_count(CFG_W'(cfg));
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 20);
      end else begin
        n = batch_size(CFG_W'(cfg)) - shadow_fill;
        if (n < 1) n = 1;
        n += batch_size(CFG_W'(cfg)) * $urandom_range(0, 2);
      end
      repeat (n) send_cell(pick_voltage());
      end_burst();
      sent += n;
      cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
    end
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    cell_count_we <= 1'b0;
    cell_count_data <= '0;
    in_valid <= 1'b0;
    voltage_mv <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_batch();
    test_small_counts();
    test_lowered_mid_batch();
    test_random_batches(32, 50, 31, 110);
    test_random_batches(50, 32, 17, 110);
    test_output_hold_off();
    test_random_batches(0, 0, 16, 110);

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_ranks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
